// ===== hdl/fbs_pkg.sv =====
// shared types, constants and helpers of the forward-backward smoother
package fbs_pkg;

    localparam int          SMP_W    = 24;
    localparam int          CFG_W    = 17;
    localparam int          IDX_W    = 10;
    localparam logic [16:0] ONE_Q16  = 17'h10000;
    localparam logic [16:0] DIL_RST  = 17'h08000;

    localparam logic CFG_DILUTION = 1'b0;
    localparam logic CFG_WRAP     = 1'b1;

    typedef struct packed {
        logic                    mode;
        logic signed [SMP_W-1:0] sample_re;
        logic signed [SMP_W-1:0] sample_im;
        logic                    final_sample;
    } t_in;

    typedef struct packed {
        logic signed [SMP_W-1:0] out_re;
        logic signed [SMP_W-1:0] out_im;
        logic [IDX_W-1:0]        point_index;
        logic                    final_result;
    } t_out;

    typedef struct packed {
        logic             clr_avg;
        logic             ld_prod;
        logic             ld_sum;
        logic             smp_we;
        logic             smp_load;
        logic             fwd_we;
        logic             out_ld;
        logic             out_final;
        logic [IDX_W-1:0] out_idx;
    } t_cmd;

    typedef struct packed {
        logic wrap;
    } t_sts;

    function automatic logic [SMP_W-1:0] sat_q320(input logic signed [26:0] v);
        logic [SMP_W-1:0] r;
        if (v > 27'sd8388607) begin
            r = 24'h7FFFFF;
        end else if (v < -27'sd8388608) begin
            r = 24'h800000;
        end else begin
            r = v[SMP_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/fbs_ram.sv =====
// generic simple dual-port ram with registered read
module fbs_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/fbs_dp.sv =====
// datapath: sample and forward stores, smoothing arithmetic, config and result registers
module fbs_dp #(
    parameter int MAX_POINTS = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic signed [23:0]                i_sample_re,
    input  logic signed [23:0]                i_sample_im,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_idx,
    input  logic [16:0]                       i_cfg_data,
    input  fbs_pkg::t_cmd                     i_cmd,
    input  logic [$clog2(MAX_POINTS)-1:0]     i_smp_waddr,
    input  logic [$clog2(MAX_POINTS)-1:0]     i_smp_raddr,
    input  logic [$clog2(MAX_POINTS)-1:0]     i_fwd_addr,
    output fbs_pkg::t_sts                     o_sts,
    output logic                              o_strobe,
    output fbs_pkg::t_out                     o_out
);
    import fbs_pkg::*;

    logic [16:0]        r_dilution;
    logic               r_wrap;

    logic [47:0]        w_smp_rd;
    logic [47:0]        w_smp_wd;
    logic [47:0]        w_fwd_rd;

    logic signed [23:0] w_x_re, w_x_im;
    logic signed [17:0] w_d, w_c;

    // products: tap uses x*c + avg*d, update uses x*d + avg*c
    logic signed [41:0] r_ptx_re, r_pta_re, r_pux_re, r_pua_re;
    logic signed [41:0] r_ptx_im, r_pta_im, r_pux_im, r_pua_im;

    logic [42:0]        w_tap_re_s, w_tap_im_s, w_upd_re_s, w_upd_im_s;
    logic signed [23:0] r_avg_re, r_avg_im;
    logic signed [23:0] r_tap_re, r_tap_im;
    logic [24:0]        w_mix_re_s, w_mix_im_s;

    t_out               r_out;
    logic               r_strobe;

    fbs_ram #(.WIDTH(48), .DEPTH(MAX_POINTS)) u_smp_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.smp_we),
        .i_waddr (i_smp_waddr),
        .i_wdata (w_smp_wd),
        .i_raddr (i_smp_raddr),
        .o_rdata (w_smp_rd)
    );

    fbs_ram #(.WIDTH(48), .DEPTH(MAX_POINTS)) u_fwd_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.fwd_we),
        .i_waddr (i_fwd_addr),
        .i_wdata ({r_tap_re, r_tap_im}),
        .i_raddr (i_fwd_addr),
        .o_rdata (w_fwd_rd)
    );

    // configuration, dilution above one acts as one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dilution <= DIL_RST;
            r_wrap     <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_DILUTION) begin
                r_dilution <= (i_cfg_data > ONE_Q16) ? ONE_Q16 : i_cfg_data;
            end else begin
                r_wrap <= i_cfg_data[0];
            end
        end
    end

    assign o_sts.wrap = r_wrap;

    assign w_x_re = w_smp_rd[47:24];
    assign w_x_im = w_smp_rd[23:0];
    assign w_d    = $signed({1'b0, r_dilution});
    assign w_c    = $signed({1'b0, ONE_Q16 - r_dilution});

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_prod) begin
            r_ptx_re <= w_x_re * w_c;
            r_pta_re <= r_avg_re * w_d;
            r_pux_re <= w_x_re * w_d;
            r_pua_re <= r_avg_re * w_c;
            r_ptx_im <= w_x_im * w_c;
            r_pta_im <= r_avg_im * w_d;
            r_pux_im <= w_x_im * w_d;
            r_pua_im <= r_avg_im * w_c;
        end
    end

    assign w_tap_re_s = {r_ptx_re[41], r_ptx_re} + {r_pta_re[41], r_pta_re};
    assign w_tap_im_s = {r_ptx_im[41], r_ptx_im} + {r_pta_im[41], r_pta_im};
    assign w_upd_re_s = {r_pux_re[41], r_pux_re} + {r_pua_re[41], r_pua_re};
    assign w_upd_im_s = {r_pux_im[41], r_pux_im} + {r_pua_im[41], r_pua_im};

    // bits 42:16 are the floor of the sum in q3.20
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg_re <= '0;
            r_avg_im <= '0;
        end else if (i_cmd.clr_avg) begin
            r_avg_re <= '0;
            r_avg_im <= '0;
        end else if (i_cmd.ld_sum) begin
            r_avg_re <= sat_q320(w_upd_re_s[42:16]);
            r_avg_im <= sat_q320(w_upd_im_s[42:16]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_sum) begin
            r_tap_re <= sat_q320(w_tap_re_s[42:16]);
            r_tap_im <= sat_q320(w_tap_im_s[42:16]);
        end
    end

    // mean of forward and reverse taps, floor halving never leaves the range
    assign w_mix_re_s = {w_fwd_rd[47], w_fwd_rd[47:24]} + {r_tap_re[23], r_tap_re};
    assign w_mix_im_s = {w_fwd_rd[23], w_fwd_rd[23:0]} + {r_tap_im[23], r_tap_im};

    assign w_smp_wd = i_cmd.smp_load ? {i_sample_re, i_sample_im}
                                     : {w_mix_re_s[24:1], w_mix_im_s[24:1]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_out.out_re       <= w_smp_rd[47:24];
            r_out.out_im       <= w_smp_rd[23:0];
            r_out.point_index  <= i_cmd.out_idx;
            r_out.final_result <= i_cmd.out_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.out_ld;
        end
    end

    assign o_out    = r_out;
    assign o_strobe = r_strobe;

endmodule

// ===== hdl/fbs_ctrl.sv =====
// controller: loading, forward and reverse passes with warmup, result readout
module fbs_ctrl #(
    parameter int MAX_POINTS = 1024,
    parameter int WARMUP_LEN = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_mode,
    input  logic                          i_final,
    output logic                          o_busy,
    input  fbs_pkg::t_sts                 i_sts,
    output fbs_pkg::t_cmd                 o_cmd,
    output logic [$clog2(MAX_POINTS)-1:0] o_smp_waddr,
    output logic [$clog2(MAX_POINTS)-1:0] o_smp_raddr,
    output logic [$clog2(MAX_POINTS)-1:0] o_fwd_addr
);
    import fbs_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [10:0] {
        ST_LOAD    = 11'b000_0000_0001,
        ST_FW_RD   = 11'b000_0000_0010,
        ST_FW_MUL  = 11'b000_0000_0100,
        ST_FW_SUM  = 11'b000_0000_1000,
        ST_FW_WR   = 11'b000_0001_0000,
        ST_RV_RD   = 11'b000_0010_0000,
        ST_RV_MUL  = 11'b000_0100_0000,
        ST_RV_SUM  = 11'b000_1000_0000,
        ST_RV_WR   = 11'b001_0000_0000,
        ST_RD_WAIT = 11'b010_0000_0000,
        ST_READ    = 11'b100_0000_0000
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_rp, n_rp;
    logic [AW-1:0]   r_i, n_i;
    logic            r_warm, n_warm;
    logic            r_warm_en, n_warm_en;

    logic            w_accept;
    logic            w_full;
    logic [CW-1:0]   w_cnt_inc;
    logic            w_warm;
    logic            w_at_end;
    logic            w_at_zero;
    logic            w_in_pass;
    logic [AW-1:0]   w_rd_addr;

    assign o_busy    = !(r_state == ST_LOAD || r_state == ST_READ);
    assign w_accept  = i_start && !o_busy;
    assign w_full    = (r_count == CW'(MAX_POINTS));
    assign w_cnt_inc = w_full ? r_count : r_count + CW'(1);
    assign w_warm    = i_sts.wrap && (int'(w_cnt_inc) > WARMUP_LEN);
    assign w_at_end  = (CW'(r_i) == r_count - CW'(1));
    assign w_at_zero = (r_i == '0);
    assign w_rd_addr = AW'(r_rp - CW'(1));
    assign w_in_pass = !(r_state == ST_LOAD || r_state == ST_RD_WAIT || r_state == ST_READ);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rp        = r_rp;
        n_i         = r_i;
        n_warm      = r_warm;
        n_warm_en   = r_warm_en;
        o_cmd       = '0;
        o_cmd.out_idx   = IDX_W'(int'(r_rp) - 1);
        o_cmd.out_final = (r_rp == CW'(1));
        o_smp_waddr = r_i;
        o_smp_raddr = r_i;
        o_fwd_addr  = r_i;
        case (r_state)
            ST_LOAD: begin
                o_smp_waddr    = r_count[AW-1:0];
                o_cmd.smp_load = 1'b1;
                if (w_accept && !i_mode) begin
                    o_cmd.smp_we = !w_full;
                    n_count      = w_cnt_inc;
                    if (i_final) begin
                        o_cmd.clr_avg = 1'b1;
                        n_warm_en     = w_warm;
                        n_warm        = w_warm;
                        n_i           = w_warm ? AW'(w_cnt_inc - CW'(WARMUP_LEN)) : '0;
                        n_state       = ST_FW_RD;
                    end
                end
            end
            ST_FW_RD: begin
                n_state = ST_FW_MUL;
            end
            ST_FW_MUL: begin
                o_cmd.ld_prod = 1'b1;
                n_state       = ST_FW_SUM;
            end
            ST_FW_SUM: begin
                o_cmd.ld_sum = 1'b1;
                if (r_warm) begin
                    n_state = ST_FW_RD;
                    if (w_at_end) begin
                        n_i    = '0;
                        n_warm = 1'b0;
                    end else begin
                        n_i = r_i + AW'(1);
                    end
                end else begin
                    n_state = ST_FW_WR;
                end
            end
            ST_FW_WR: begin
                o_cmd.fwd_we = 1'b1;
                if (w_at_end) begin
                    // reverse warmup runs from point WARMUP_LEN down to zero
                    o_cmd.clr_avg = 1'b1;
                    n_warm        = r_warm_en;
                    n_i           = r_warm_en ? AW'(WARMUP_LEN) : AW'(r_count - CW'(1));
                    n_state       = ST_RV_RD;
                end else begin
                    n_i     = r_i + AW'(1);
                    n_state = ST_FW_RD;
                end
            end
            ST_RV_RD: begin
                n_state = ST_RV_MUL;
            end
            ST_RV_MUL: begin
                o_cmd.ld_prod = 1'b1;
                n_state       = ST_RV_SUM;
            end
            ST_RV_SUM: begin
                o_cmd.ld_sum = 1'b1;
                if (r_warm) begin
                    n_state = ST_RV_RD;
                    if (w_at_zero) begin
                        n_i    = AW'(r_count - CW'(1));
                        n_warm = 1'b0;
                    end else begin
                        n_i = r_i - AW'(1);
                    end
                end else begin
                    n_state = ST_RV_WR;
                end
            end
            ST_RV_WR: begin
                o_cmd.smp_we = 1'b1;
                if (w_at_zero) begin
                    n_rp    = r_count;
                    n_state = ST_RD_WAIT;
                end else begin
                    n_i     = r_i - AW'(1);
                    n_state = ST_RV_RD;
                end
            end
            ST_RD_WAIT: begin
                // wait state for the registered store read
                o_smp_raddr = w_rd_addr;
                n_state     = ST_READ;
            end
            ST_READ: begin
                o_smp_raddr = w_rd_addr;
                if (w_accept && i_mode) begin
                    o_cmd.out_ld = 1'b1;
                    n_rp         = r_rp - CW'(1);
                    if (r_rp == CW'(1)) begin
                        n_count = '0;
                        n_state = ST_LOAD;
                    end else begin
                        n_state = ST_RD_WAIT;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_count   <= '0;
            r_rp      <= '0;
            r_i       <= '0;
            r_warm    <= 1'b0;
            r_warm_en <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_rp      <= n_rp;
            r_i       <= n_i;
            r_warm    <= n_warm;
            r_warm_en <= n_warm_en;
        end
    end

    a_read_then_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_ld |=> (r_state == ST_RD_WAIT || r_state == ST_LOAD))
        else $error("result not followed by a store read wait");

    a_index_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_pass |-> (CW'(r_i) < r_count))
        else $error("pass index outside loaded block");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= MAX_POINTS)
        else $error("point count above store depth");

    a_read_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> (r_rp != '0 && r_rp <= r_count))
        else $error("read pointer outside block while reading");

endmodule

// ===== hdl/forward_backward_smoother.sv =====
// top level of the zero-phase exponential smoother
//
// Usage: items enter on start/i_in and are taken when start is high and busy is low.
// A load item (mode 0) stores one q3.20 complex sample; the item with
// final_sample set starts filtering and busy stays high through both passes, which
// include warmups when wrap mode is on and the block has more than WARMUP_LEN points.
// Both passes run point by point through one shared multiply/sum unit: store read,
// products, sum and store write for each point, with no store write in warmup.
// A read item (mode 1) returns the next filtered point, highest index first, on
// o_out with o_strobe high for one cycle, in the cycle after the item is taken; busy
// then stays high while the store reads the next point, so the next read waits for it.
// The result with final_result set is index zero; loading may resume after it.
// Reads while loading and loads while reading are taken and ignored.
// Configuration: i_cfg_we with index 0 writes dilution (q1.16, clamped to one),
// index 1 writes wrap mode; write only while no work is in flight.
// Reset clears the control state, dilution to one half and wrap mode off.
// Results cannot be held off by the receiver.
module forward_backward_smoother #(
    parameter int MAX_POINTS = 1024,
    parameter int WARMUP_LEN = 20
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  fbs_pkg::t_in  i_in,
    output logic          o_strobe,
    output fbs_pkg::t_out o_out,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [16:0]   i_cfg_data
);
    import fbs_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);

    t_cmd          w_cmd;
    t_sts          w_sts;
    logic [AW-1:0] w_smp_waddr;
    logic [AW-1:0] w_smp_raddr;
    logic [AW-1:0] w_fwd_addr;

    fbs_ctrl #(
        .MAX_POINTS (MAX_POINTS),
        .WARMUP_LEN (WARMUP_LEN)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_mode      (i_in.mode),
        .i_final     (i_in.final_sample),
        .o_busy      (busy),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_smp_waddr (w_smp_waddr),
        .o_smp_raddr (w_smp_raddr),
        .o_fwd_addr  (w_fwd_addr)
    );

    fbs_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample_re (i_in.sample_re),
        .i_sample_im (i_in.sample_im),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .i_smp_waddr (w_smp_waddr),
        .i_smp_raddr (w_smp_raddr),
        .i_fwd_addr  (w_fwd_addr),
        .o_sts       (w_sts),
        .o_strobe    (o_strobe),
        .o_out       (o_out)
    );

endmodule

// ===== dv/tb_top.sv =====
// testbench for the forward-backward smoother: predicts every filtered point and checks it
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fbs_pkg::*;

    localparam int MAX_PTS    = 1024;
    localparam int WARM_PTS   = 20;
    localparam int STALL_LIMIT = 40000;

    class smoother_scoreboard;
        longint smp_re [MAX_PTS];
        longint smp_im [MAX_PTS];
        longint fwd_re [MAX_PTS];
        longint fwd_im [MAX_PTS];
        longint dil;
        bit     wrap;
        int     n_pts;
        int     rd_ptr;
        bit     reading;
        int     n_err;
        t_out   filtered_q[$];

        function new();
            dil     = longint'(DIL_RST);
            wrap    = 1'b0;
            n_pts   = 0;
            rd_ptr  = 0;
            reading = 1'b0;
            n_err   = 0;
        endfunction

        function longint sat24(longint v);
            if (v > 64'sd8388607) return 64'sd8388607;
            if (v < -64'sd8388608) return -64'sd8388608;
            return v;
        endfunction

        // a*wa + b*wb, q3.20 by q1.16, floored back to q3.20
        function void blend(input longint a_re, input longint a_im, input longint wa,
                            input longint b_re, input longint b_im, input longint wb,
                            output longint r_re, output longint r_im);
            r_re = sat24((a_re * wa + b_re * wb) >>> 16);
            r_im = sat24((a_im * wa + b_im * wb) >>> 16);
        endfunction

        function void smooth_block();
            longint keep;
            longint avg_re, avg_im, tap_re, tap_im;
            bit     warm;
            keep = longint'(ONE_Q16) - dil;
            warm = wrap && (n_pts > WARM_PTS);
            avg_re = 0;
            avg_im = 0;
            if (warm) begin
                for (int i = n_pts - WARM_PTS; i < n_pts; i++)
                    blend(smp_re[i], smp_im[i], dil, avg_re, avg_im, keep, avg_re, avg_im);
            end
            for (int i = 0; i < n_pts; i++) begin
                blend(smp_re[i], smp_im[i], keep, avg_re, avg_im, dil, tap_re, tap_im);
                blend(smp_re[i], smp_im[i], dil, avg_re, avg_im, keep, avg_re, avg_im);
                fwd_re[i] = tap_re;
                fwd_im[i] = tap_im;
            end
            avg_re = 0;
            avg_im = 0;
            if (warm) begin
                for (int i = WARM_PTS; i >= 0; i--)
                    blend(smp_re[i], smp_im[i], dil, avg_re, avg_im, keep, avg_re, avg_im);
            end
            // reverse pass overwrites each point with the mean of both taps
            for (int i = n_pts - 1; i >= 0; i--) begin
                blend(smp_re[i], smp_im[i], keep, avg_re, avg_im, dil, tap_re, tap_im);
                blend(smp_re[i], smp_im[i], dil, avg_re, avg_im, keep, avg_re, avg_im);
                smp_re[i] = sat24((fwd_re[i] + tap_re) >>> 1);
                smp_im[i] = sat24((fwd_im[i] + tap_im) >>> 1);
            end
        endfunction

        function void write_reg(input logic idx, input logic [16:0] data);
            if (idx == CFG_DILUTION)
                dil = (data > ONE_Q16) ? longint'(ONE_Q16) : longint'(data);
            else
                wrap = data[0];
        endfunction

        function void note_item(input t_in it);
            t_out w;
            int   idx;
            if (it.mode == 1'b0) begin
                if (reading) return;
                if (n_pts < MAX_PTS) begin
                    smp_re[n_pts] = it.sample_re;
                    smp_im[n_pts] = it.sample_im;
                    n_pts++;
                end
                if (it.final_sample && n_pts > 0) begin
                    smooth_block();
                    rd_ptr  = n_pts;
                    reading = 1'b1;
                end
                return;
            end
            if (!reading || rd_ptr == 0) return;
            idx = rd_ptr - 1;
            rd_ptr = idx;
            w.out_re       = smp_re[idx][23:0];
            w.out_im       = smp_im[idx][23:0];
            w.point_index  = 10'(idx);
            w.final_result = (idx == 0);
            filtered_q.push_back(w);
            if (idx == 0) begin
                reading = 1'b0;
                n_pts   = 0;
            end
        endfunction

        task flag_mismatch(input string what, input longint got, input longint want);
            $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
            n_err++;
        endtask

        task check_point(input t_out got);
            t_out w;
            if (filtered_q.size() == 0) begin
                flag_mismatch("unexpected point, index", got.point_index, -1);
                return;
            end
            w = filtered_q.pop_front();
            if (got.out_re !== w.out_re)
                flag_mismatch("out_re", got.out_re, w.out_re);
            if (got.out_im !== w.out_im)
                flag_mismatch("out_im", got.out_im, w.out_im);
            if (got.point_index !== w.point_index)
                flag_mismatch("point_index", got.point_index, w.point_index);
            if (got.final_result !== w.final_result)
                flag_mismatch("final_result", got.final_result, w.final_result);
        endtask

        function int pending();
            return filtered_q.size();
        endfunction
    endclass

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        start      = 1'b0;
    logic        busy;
    t_in         i_in       = '0;
    logic        o_strobe;
    t_out        o_out;
    logic        i_cfg_we   = 1'b0;
    logic        i_cfg_idx  = 1'b0;
    logic [16:0] i_cfg_data = '0;

    smoother_scoreboard sb = new();
    bit burst;
    int items_done;
    int stall_cycles;

    forward_backward_smoother dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_in       (i_in),
        .o_strobe   (o_strobe),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // result check and stall watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe === 1'b1)
                sb.check_point(o_out);
            if (o_strobe === 1'b1 || (start && !busy))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    function automatic logic [23:0] pick_val();
        case ($urandom_range(0, 7))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'h000000;
            3: return 24'hFFFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic t_in mk_load(input logic [23:0] re, input logic [23:0] im, input bit last);
        t_in it;
        it.mode         = 1'b0;
        it.sample_re    = re;
        it.sample_im    = im;
        it.final_sample = last;
        return it;
    endfunction

    function automatic t_in mk_read();
        t_in it;
        it.mode         = 1'b1;
        it.sample_re    = 24'($urandom);
        it.sample_im    = 24'($urandom);
        it.final_sample = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic logic [16:0] pick_dil();
        case ($urandom_range(0, 7))
            0: return 17'd0;
            1: return 17'd1;
            2: return 17'd65535;
            3: return ONE_Q16;
            4: return 17'h1FFFF;
            5: return DIL_RST;
            default: return 17'($urandom);
        endcase
    endfunction

    // start stays high between back-to-back items
    task automatic send_item(input t_in it);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_in  <= it;
        do @(posedge i_clk); while (busy);
        sb.note_item(it);
    endtask

    task automatic write_reg(input logic idx, input logic [16:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic set_regs(input logic [16:0] dil, input bit wrap);
        start <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        write_reg(CFG_DILUTION, dil);
        write_reg(CFG_WRAP, {16'd0, wrap});
        i_cfg_we <= 1'b0;
    endtask

    // one wave: loads with stray reads, then read-back with stray loads
    task automatic run_block(input int n);
        int n_rd;
        n_rd = (n < MAX_PTS) ? n : MAX_PTS;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 15) == 0)
                send_item(mk_read());
            send_item(mk_load(pick_val(), pick_val(), i == n - 1));
        end
        for (int i = 0; i < n_rd; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_item(mk_load(pick_val(), pick_val(), 1'($urandom_range(0, 1))));
            send_item(mk_read());
        end
        items_done += n + n_rd;
    endtask

    function automatic int pick_len();
        case ($urandom_range(0, 5))
            0: return $urandom_range(1, 3);
            1: return $urandom_range(20, 22);
            2: return $urandom_range(23, 60);
            default: return $urandom_range(1, 19);
        endcase
    endfunction

    initial begin
        burst = 1'b0;
        items_done = 0;
        stall_cycles = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: read on an empty store, extremes, a load while reading
        send_item(mk_read());
        send_item(mk_load(24'h7FFFFF, 24'h800000, 1'b0));
        send_item(mk_load(24'h800000, 24'h7FFFFF, 1'b0));
        send_item(mk_load(24'h000000, 24'hFFFFFF, 1'b1));
        send_item(mk_load(24'h123456, 24'hABCDEF, 1'b1));
        repeat (3) send_item(mk_read());

        // zero dilution, single point
        set_regs(17'd0, 1'b0);
        send_item(mk_load(24'h800000, 24'h7FFFFF, 1'b1));
        send_item(mk_read());

        // dilution above one clamps; wrap on but block too short to warm up
        set_regs(17'h1FFFF, 1'b1);
        send_item(mk_load(24'h7FFFFF, 24'h7FFFFF, 1'b0));
        send_item(mk_load(24'hFFFFFF, 24'h000000, 1'b1));
        repeat (2) send_item(mk_read());

        // warm-up boundaries
        set_regs(17'd1, 1'b1);
        run_block(21);
        set_regs(ONE_Q16, 1'b1);
        run_block(20);

        while (items_done < 340) begin
            if ($urandom_range(0, 2) == 0)
                set_regs(pick_dil(), 1'($urandom_range(0, 1)));
            burst = ($urandom_range(0, 3) == 0);
            run_block(pick_len());
        end

        start <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (sb.n_err == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
